// ----- src/mco_pkg.sv -----
// Package for the midpoint circle outline block: widths, queue sizing,
// the step record passed from front to back, and queue status struct.
// No dependencies.
package mco_pkg;

    localparam int COORD_WIDTH     = 15;
    localparam int RADIUS_WIDTH    = 14;
    localparam int COLOR_WIDTH     = 32;
    localparam int PIX_W           = COORD_WIDTH + 1;
    localparam int MAJ_W           = RADIUS_WIDTH + 2;
    localparam int MIN_W           = RADIUS_WIDTH + 1;
    localparam int ERR_W           = RADIUS_WIDTH + 3;
    localparam int SUM_W           = (PIX_W > MAJ_W) ? PIX_W : MAJ_W;
    localparam int POINTS_PER_STEP = 8;
    localparam int PT_W            = $clog2(POINTS_PER_STEP);
    localparam int QUEUE_DEPTH     = 2;
    localparam int Q_AW            = $clog2(QUEUE_DEPTH);
    localparam int Q_CW            = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // One step's worth of work: offsets before the update, plus end flag.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [MAJ_W-1:0]       maj;
        logic [MIN_W-1:0]              min;
        logic [COLOR_WIDTH-1:0]        color;
        logic                          done;
    } t_step;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

// ----- src/mco_front.sv -----
// Front end: accepts command words, holds the circle's running terms and
// pushes one step record per drawing step. Depends on mco_pkg.
module mco_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_command,
    input  logic signed [mco_pkg::COORD_WIDTH-1:0] i_center_x,
    input  logic signed [mco_pkg::COORD_WIDTH-1:0] i_center_y,
    input  logic [mco_pkg::RADIUS_WIDTH-1:0]    i_radius,
    input  logic [mco_pkg::COLOR_WIDTH-1:0]     i_color,
    input  mco_pkg::t_q_stat                    i_q_stat,
    output logic                                o_push,
    output mco_pkg::t_step                      o_push_data
);

    logic signed [mco_pkg::COORD_WIDTH-1:0] r_cx, r_cy;
    logic signed [mco_pkg::MAJ_W-1:0]       r_maj, n_maj;
    logic [mco_pkg::MIN_W-1:0]              r_min, n_min;
    logic [mco_pkg::MAJ_W-1:0]              r_step_maj, n_step_maj;
    logic [mco_pkg::MAJ_W-1:0]              r_step_min, n_step_min;
    logic signed [mco_pkg::ERR_W-1:0]       r_err, n_err;
    logic [mco_pkg::MIN_W-1:0]              r_twice;
    logic [mco_pkg::COLOR_WIDTH-1:0]        r_color;
    logic                                   r_active;

    logic                                   accept;
    logic signed [mco_pkg::ERR_W-1:0]       e1;
    logic signed [mco_pkg::ERR_W-1:0]       sm_ext, smj_ext, twice_ext;
    logic signed [mco_pkg::MAJ_W-1:0]       min_s;
    logic                                   done;

    assign o_ready = !i_q_stat.full;
    assign accept  = i_valid && o_ready;

    assign sm_ext    = mco_pkg::ERR_W'(r_step_min);
    assign twice_ext = mco_pkg::ERR_W'(r_twice);

    // Minor-axis update, then major-axis update on the refreshed error.
    always_comb begin
        n_min      = r_min;
        n_step_min = r_step_min;
        e1         = r_err;
        if (r_err <= 0) begin
            n_min      = r_min + mco_pkg::MIN_W'(1);
            n_step_min = r_step_min + mco_pkg::MAJ_W'(2);
            e1         = r_err + sm_ext;
        end
        n_maj      = r_maj;
        n_step_maj = r_step_maj;
        n_err      = e1;
        if (e1 > 0) begin
            n_maj      = r_maj - mco_pkg::MAJ_W'(1);
            n_step_maj = r_step_maj + mco_pkg::MAJ_W'(2);
            n_err      = e1 + smj_ext - twice_ext;
        end
    end

    assign smj_ext = mco_pkg::ERR_W'(r_step_maj + mco_pkg::MAJ_W'(2));
    assign min_s   = mco_pkg::MAJ_W'(n_min);
    assign done    = n_maj < min_s;

    assign o_push = accept && (i_command == mco_pkg::CMD_STEP) && r_active;

    always_comb begin
        o_push_data.cx    = r_cx;
        o_push_data.cy    = r_cy;
        o_push_data.maj   = r_maj;
        o_push_data.min   = r_min;
        o_push_data.color = r_color;
        o_push_data.done  = done;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (accept && i_command == mco_pkg::CMD_START) begin
            r_active <= (i_radius != '0);
        end else if (o_push && done) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_command == mco_pkg::CMD_START) begin
            r_cx       <= i_center_x;
            r_cy       <= i_center_y;
            r_color    <= i_color;
            r_twice    <= {i_radius, 1'b0};
            r_maj      <= mco_pkg::MAJ_W'(i_radius) - mco_pkg::MAJ_W'(1);
            r_min      <= '0;
            r_step_maj <= mco_pkg::MAJ_W'(1);
            r_step_min <= mco_pkg::MAJ_W'(1);
            r_err      <= mco_pkg::ERR_W'(1) - mco_pkg::ERR_W'({i_radius, 1'b0});
        end else if (o_push) begin
            r_maj      <= n_maj;
            r_min      <= n_min;
            r_step_maj <= n_step_maj;
            r_step_min <= n_step_min;
            r_err      <= n_err;
        end
    end

endmodule

// ----- src/mco_queue.sv -----
// Short register queue of step records between front and back.
// Depends on mco_pkg.
module mco_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  mco_pkg::t_step    i_push_data,
    input  logic              i_pop,
    output mco_pkg::t_step    o_head,
    output mco_pkg::t_q_stat  o_stat
);

    mco_pkg::t_step               r_mem [mco_pkg::QUEUE_DEPTH];
    logic [mco_pkg::Q_AW-1:0]     r_wr, r_rd;
    logic [mco_pkg::Q_CW-1:0]     r_cnt;

    assign o_head       = r_mem[r_rd];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == mco_pkg::Q_CW'(mco_pkg::QUEUE_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == mco_pkg::Q_AW'(mco_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == mco_pkg::Q_AW'(mco_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ----- src/mco_back.sv -----
// Back end: walks the eight mirrored points of the head step record and
// drives the registered point output. Depends on mco_pkg.
module mco_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mco_pkg::t_step                       i_head,
    input  mco_pkg::t_q_stat                     i_q_stat,
    output logic                                 o_pop,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [mco_pkg::PIX_W-1:0]     o_pixel_x,
    output logic signed [mco_pkg::PIX_W-1:0]     o_pixel_y,
    output logic [mco_pkg::COLOR_WIDTH-1:0]      o_pixel_color,
    output logic                                 o_last_of_step,
    output logic                                 o_circle_done
);

    logic [mco_pkg::PT_W-1:0]          r_pt;
    logic                              r_valid;
    logic                              load;
    logic                              last_pt;
    logic signed [mco_pkg::SUM_W-1:0]  a_ext, b_ext, cx_ext, cy_ext, u, v;
    logic signed [mco_pkg::SUM_W-1:0]  x_sum, y_sum;

    assign load    = !i_q_stat.empty && (!r_valid || i_ready);
    assign last_pt = (r_pt == mco_pkg::PT_W'(mco_pkg::POINTS_PER_STEP - 1));
    assign o_pop   = load && last_pt;
    assign o_valid = r_valid;

    assign a_ext  = mco_pkg::SUM_W'(i_head.maj);
    assign b_ext  = mco_pkg::SUM_W'({1'b0, i_head.min});
    assign cx_ext = mco_pkg::SUM_W'(i_head.cx);
    assign cy_ext = mco_pkg::SUM_W'(i_head.cy);

    // Point order: bit 2 swaps the axes, bit 1 negates x, bit 0 keeps y positive.
    always_comb begin
        u     = r_pt[2] ? b_ext : a_ext;
        v     = r_pt[2] ? a_ext : b_ext;
        x_sum = r_pt[1] ? cx_ext - u : cx_ext + u;
        y_sum = r_pt[0] ? cy_ext + v : cy_ext - v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pt    <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_pt    <= r_pt + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_pixel_x      <= mco_pkg::PIX_W'(x_sum);
            o_pixel_y      <= mco_pkg::PIX_W'(y_sum);
            o_pixel_color  <= i_head.color;
            o_last_of_step <= last_pt;
            o_circle_done  <= last_pt && i_head.done;
        end
    end

endmodule

// ----- src/midpoint_circle_outline.sv -----
// Top level of the midpoint circle outline rasterizer.
// Depends on mco_pkg, mco_front, mco_queue and mco_back.
//
// Usage:
//   Input channel (i_valid / o_ready) takes one command word per handshake.
//   A start word (i_command = 0) latches center, radius and color and
//   primes the running terms; it produces no output. A step word
//   (i_command = 1) on an active circle produces eight point words on the
//   output channel (o_valid / i_ready); a step with no circle in progress
//   produces nothing. A start of radius zero leaves no circle in progress.
//   The eighth point of each step carries o_last_of_step, and the eighth
//   point of the step that closes the circle also carries o_circle_done.
// Path: with the back end idle, the record of an accepted step word enters
//   the queue, and the back end loads the step's first point from the queue
//   head into the output register.
// Throughput: one point per cycle while i_ready is high and a step waits in
//   the queue; the single output register, fed at one point a cycle, sets that rate.
//   The front keeps taking words while the two-entry step queue has room,
//   so start words and the next step overlap the current step's points.
// Stall: while i_ready is low the output word holds and the queue fills;
//   o_ready drops once both queue entries are taken.
// Reset: i_rst_n low clears the queue, the output valid and the active
//   flag; no circle is in progress afterwards.
module midpoint_circle_outline (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  logic                                    i_command,
    input  logic signed [mco_pkg::COORD_WIDTH-1:0]  i_center_x,
    input  logic signed [mco_pkg::COORD_WIDTH-1:0]  i_center_y,
    input  logic [mco_pkg::RADIUS_WIDTH-1:0]        i_radius,
    input  logic [mco_pkg::COLOR_WIDTH-1:0]         i_color,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output logic signed [mco_pkg::PIX_W-1:0]        o_pixel_x,
    output logic signed [mco_pkg::PIX_W-1:0]        o_pixel_y,
    output logic [mco_pkg::COLOR_WIDTH-1:0]         o_pixel_color,
    output logic                                    o_last_of_step,
    output logic                                    o_circle_done
);

    // Step records flow front -> queue -> back.
    logic              push, pop;
    mco_pkg::t_step    push_data, head;
    mco_pkg::t_q_stat  q_stat;

    // Accept words, advance the circle terms, emit step records.
    mco_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_command   (i_command),
        .i_center_x  (i_center_x),
        .i_center_y  (i_center_y),
        .i_radius    (i_radius),
        .i_color     (i_color),
        .i_q_stat    (q_stat),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // Hold pending steps so either side can stall alone.
    mco_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_stat      (q_stat)
    );

    // Expand each step into its eight mirrored points.
    mco_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_q_stat       (q_stat),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

endmodule

// ----- src/mco_checker.sv -----
// Port-level checks for the midpoint circle outline block, bound to the
// top level. Depends on mco_pkg and midpoint_circle_outline.
module mco_checker (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    input  logic                                    o_ready,
    input  logic                                    i_command,
    input  logic signed [mco_pkg::COORD_WIDTH-1:0]  i_center_x,
    input  logic signed [mco_pkg::COORD_WIDTH-1:0]  i_center_y,
    input  logic [mco_pkg::RADIUS_WIDTH-1:0]        i_radius,
    input  logic [mco_pkg::COLOR_WIDTH-1:0]         i_color,
    input  logic                                    o_valid,
    input  logic                                    i_ready,
    input  logic signed [mco_pkg::PIX_W-1:0]        o_pixel_x,
    input  logic signed [mco_pkg::PIX_W-1:0]        o_pixel_y,
    input  logic [mco_pkg::COLOR_WIDTH-1:0]         o_pixel_color,
    input  logic                                    o_last_of_step,
    input  logic                                    o_circle_done
);

    // A waiting command word holds still.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_command) && $stable(i_center_x)
                                && $stable(i_center_y) && $stable(i_radius)
                                && $stable(i_color))
        else $error("input word changed while waiting");

    // A stalled point word holds still.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_x) && $stable(o_pixel_y)
                                && $stable(o_last_of_step))
        else $error("output word changed under stall");

    // The circle ends only on the closing point of a step.
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_circle_done |-> o_last_of_step)
        else $error("circle_done without last_of_step");

    // Points of one step come without gaps.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_step |=> o_valid)
        else $error("gap inside a step");

    // All points of one step share the latched color.
    a_color_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last_of_step |=> o_pixel_color == $past(o_pixel_color))
        else $error("color changed inside a step");

endmodule

bind midpoint_circle_outline mco_checker u_mco_checker (.*);

// ----- tb/mco_pixel_checker.sv -----
`timescale 1ns / 1ps
// Checker for the midpoint circle outline block: predicts point words from the
// accepted command words and compares them with the pixel channel.
// Depends on mco_pkg.
module mco_pixel_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    input  logic                                   i_in_ready,
    input  logic                                   i_command,
    input  logic signed [mco_pkg::COORD_WIDTH-1:0] i_center_x,
    input  logic signed [mco_pkg::COORD_WIDTH-1:0] i_center_y,
    input  logic [mco_pkg::RADIUS_WIDTH-1:0]       i_radius,
    input  logic [mco_pkg::COLOR_WIDTH-1:0]        i_color,
    input  logic                                   i_out_valid,
    input  logic                                   i_out_ready,
    input  logic signed [mco_pkg::PIX_W-1:0]       i_pixel_x,
    input  logic signed [mco_pkg::PIX_W-1:0]       i_pixel_y,
    input  logic [mco_pkg::COLOR_WIDTH-1:0]        i_pixel_color,
    input  logic                                   i_last_of_step,
    input  logic                                   i_circle_done,
    output int                                     o_fail_count,
    output int                                     o_pending
);

    typedef struct {
        logic signed [mco_pkg::PIX_W-1:0] px;
        logic signed [mco_pkg::PIX_W-1:0] py;
        logic [mco_pkg::COLOR_WIDTH-1:0]  color;
        logic                             last;
        logic                             done;
    } t_pixel_word;

    // Circle state as the block holds it.
    logic signed [mco_pkg::COORD_WIDTH-1:0] ctr_col;
    logic signed [mco_pkg::COORD_WIDTH-1:0] ctr_row;
    logic signed [mco_pkg::MAJ_W-1:0]       off_major;
    logic [mco_pkg::MIN_W-1:0]              off_minor;
    logic [mco_pkg::MAJ_W-1:0]              inc_major;
    logic [mco_pkg::MAJ_W-1:0]              inc_minor;
    logic signed [mco_pkg::ERR_W-1:0]       decision;
    logic [mco_pkg::MIN_W-1:0]              diameter;
    logic [mco_pkg::COLOR_WIDTH-1:0]        latched_color;
    logic                                   drawing;

    t_pixel_word expected_pixels[$];
    int          pixels_seen;

    task automatic report(input string msg);
        $display("%0t ns: pixel %0d: %s", $time, pixels_seen, msg);
        o_fail_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report($sformatf("%s is %h, expected %h", name, got, want));
    endtask

    task automatic add_pixel(input int x, input int y, input logic last,
                             input logic done);
        t_pixel_word w;
        w.px    = x[mco_pkg::PIX_W-1:0];
        w.py    = y[mco_pkg::PIX_W-1:0];
        w.color = latched_color;
        w.last  = last;
        w.done  = done;
        expected_pixels.push_back(w);
    endtask

    task automatic predict_word();
        int   a, b, e, cx, cy, nmaj, nmin, smaj, smin;
        logic done;
        if (i_command == mco_pkg::CMD_START) begin
            ctr_col       = i_center_x;
            ctr_row       = i_center_y;
            latched_color = i_color;
            diameter      = {i_radius, 1'b0};
            off_major     = mco_pkg::MAJ_W'(int'(i_radius) - 1);
            off_minor     = '0;
            inc_major     = mco_pkg::MAJ_W'(1);
            inc_minor     = mco_pkg::MAJ_W'(1);
            decision      = mco_pkg::ERR_W'(1 - 2 * int'(i_radius));
            drawing       = (i_radius != 0);
        end else if (drawing) begin
            a    = int'(off_major);
            b    = int'(off_minor);
            e    = int'(decision);
            smaj = int'(inc_major);
            smin = int'(inc_minor);
            cx   = int'(ctr_col);
            cy   = int'(ctr_row);
            nmaj = a;
            nmin = b;
            // The two error updates run one after the other.
            if (e <= 0) begin
                nmin += 1;
                e    += smin;
                smin += 2;
            end
            if (e > 0) begin
                nmaj -= 1;
                smaj += 2;
                e    += smaj - int'(diameter);
            end
            done      = (nmaj < nmin);
            drawing   = !done;
            off_major = mco_pkg::MAJ_W'(nmaj);
            off_minor = mco_pkg::MIN_W'(nmin);
            inc_major = mco_pkg::MAJ_W'(smaj);
            inc_minor = mco_pkg::MAJ_W'(smin);
            decision  = mco_pkg::ERR_W'(e);
            add_pixel(cx + a, cy - b, 1'b0, 1'b0);
            add_pixel(cx + a, cy + b, 1'b0, 1'b0);
            add_pixel(cx - a, cy - b, 1'b0, 1'b0);
            add_pixel(cx - a, cy + b, 1'b0, 1'b0);
            add_pixel(cx + b, cy - a, 1'b0, 1'b0);
            add_pixel(cx + b, cy + a, 1'b0, 1'b0);
            add_pixel(cx - b, cy - a, 1'b0, 1'b0);
            add_pixel(cx - b, cy + a, 1'b1, done);
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_word w;
        if (!i_rst_n) begin
            ctr_col       = '0;
            ctr_row       = '0;
            off_major     = '0;
            off_minor     = '0;
            inc_major     = '0;
            inc_minor     = '0;
            decision      = '0;
            diameter      = '0;
            latched_color = '0;
            drawing       = 1'b0;
            o_fail_count  = 0;
            pixels_seen   = 0;
            expected_pixels.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    report($sformatf("unexpected point (%0d,%0d)", i_pixel_x, i_pixel_y));
                end else begin
                    w = expected_pixels.pop_front();
                    check_field("pixel_x", 32'(i_pixel_x), 32'(w.px));
                    check_field("pixel_y", 32'(i_pixel_y), 32'(w.py));
                    check_field("pixel_color", i_pixel_color, w.color);
                    check_field("last_of_step", 32'(i_last_of_step), 32'(w.last));
                    check_field("circle_done", 32'(i_circle_done), 32'(w.done));
                end
                pixels_seen++;
            end
            if (i_in_valid && i_in_ready)
                predict_word();
        end
        o_pending = expected_pixels.size();
    end

endmodule

// ----- tb/midpoint_circle_outline_test.sv -----
`timescale 1ns / 1ps
// Top of the midpoint circle outline testbench: clock, reset, command stimulus,
// random stalls on the pixel channel and the verdict.
// Depends on mco_pkg, midpoint_circle_outline and mco_pixel_checker.
module midpoint_circle_outline_test;

    logic                                   i_clk;
    logic                                   i_rst_n;
    logic                                   i_valid;
    logic                                   o_ready;
    logic                                   i_command;
    logic signed [mco_pkg::COORD_WIDTH-1:0] i_center_x;
    logic signed [mco_pkg::COORD_WIDTH-1:0] i_center_y;
    logic [mco_pkg::RADIUS_WIDTH-1:0]       i_radius;
    logic [mco_pkg::COLOR_WIDTH-1:0]        i_color;
    logic                                   o_valid;
    logic                                   i_ready;
    logic signed [mco_pkg::PIX_W-1:0]       o_pixel_x;
    logic signed [mco_pkg::PIX_W-1:0]       o_pixel_y;
    logic [mco_pkg::COLOR_WIDTH-1:0]        o_pixel_color;
    logic                                   o_last_of_step;
    logic                                   o_circle_done;

    int fail_count;
    int pending_pixels;
    int words_sent;

    // Calm stretches: while set, that side never idles or stalls.
    bit in_calm;
    bit out_calm;

    midpoint_circle_outline u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_command      (i_command),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_color        (i_color),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_color  (o_pixel_color),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

    mco_pixel_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_valid),
        .i_in_ready     (o_ready),
        .i_command      (i_command),
        .i_center_x     (i_center_x),
        .i_center_y     (i_center_y),
        .i_radius       (i_radius),
        .i_color        (i_color),
        .i_out_valid    (o_valid),
        .i_out_ready    (i_ready),
        .i_pixel_x      (o_pixel_x),
        .i_pixel_y      (o_pixel_y),
        .i_pixel_color  (o_pixel_color),
        .i_last_of_step (o_last_of_step),
        .i_circle_done  (o_circle_done),
        .o_fail_count   (fail_count),
        .o_pending      (pending_pixels)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Offer one command word: idle for a drawn gap, then hold valid and the
    // payload until the block takes the word. Returns at the accepting edge.
    task automatic send_word(input logic cmd,
                             input logic signed [mco_pkg::COORD_WIDTH-1:0] cx,
                             input logic signed [mco_pkg::COORD_WIDTH-1:0] cy,
                             input logic [mco_pkg::RADIUS_WIDTH-1:0] r,
                             input logic [mco_pkg::COLOR_WIDTH-1:0] color);
        int unsigned gap;
        if ($urandom_range(0, 31) == 0)
            in_calm = !in_calm;
        gap = in_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius   <= r;
        i_color    <= color;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    // Step words carry junk in the unused fields; the block must ignore it.
    task automatic send_step();
        send_word(mco_pkg::CMD_STEP, mco_pkg::COORD_WIDTH'($urandom),
                  mco_pkg::COORD_WIDTH'($urandom), mco_pkg::RADIUS_WIDTH'($urandom),
                  $urandom);
    endtask

    task automatic send_start(input logic signed [mco_pkg::COORD_WIDTH-1:0] cx,
                              input logic signed [mco_pkg::COORD_WIDTH-1:0] cy,
                              input logic [mco_pkg::RADIUS_WIDTH-1:0] r,
                              input logic [mco_pkg::COLOR_WIDTH-1:0] color);
        send_word(mco_pkg::CMD_START, cx, cy, r, color);
    endtask

    // Pixel channel: per word, stall for a drawn number of cycles, then hold
    // ready high until a word is taken.
    initial begin
        int unsigned stall;
        i_ready  <= 1'b0;
        out_calm = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 47) == 0)
                out_calm = !out_calm;
            stall = out_calm ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    initial begin
        int unsigned kind, nsteps;
        logic [mco_pkg::RADIUS_WIDTH-1:0] r;
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_command  <= mco_pkg::CMD_STEP;
        i_center_x <= '0;
        i_center_y <= '0;
        i_radius   <= '0;
        i_color    <= '0;
        in_calm    = 1'b0;
        words_sent = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part.
        // Step right after reset: no circle in progress, nothing drawn.
        send_step();
        // Zero radius leaves no circle in progress.
        send_start(0, 0, 0, 32'h0000_0000);
        send_step();
        // Radius one at the top corner of the plane, then a step past the end.
        send_start(16383, 16383, 1, 32'hFFFF_FFFF);
        send_step();
        send_step();
        // Largest radius at both corners: widest pixel coordinates.
        send_start(-16384, -16384, 16383, 32'h0000_0000);
        send_step();
        send_step();
        // Start while drawing: drop the big circle for another one.
        send_start(16383, -16384, 16383, 32'hA5A5_A5A5);
        send_step();
        send_start(-16384, 16383, 2, 32'h5A5A_5A5A);
        repeat (4) send_step();
        send_start(-1, 1, 5, 32'h1234_5678);
        repeat (5) send_step();

        // Random part: mostly whole circles of small radius with random
        // center and color, a few huge ones cut short, and some noise.
        while (words_sent < 220) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                send_word(1'($urandom_range(0, 1)), mco_pkg::COORD_WIDTH'($urandom),
                          mco_pkg::COORD_WIDTH'($urandom),
                          mco_pkg::RADIUS_WIDTH'($urandom), $urandom);
            end else begin
                r = ($urandom_range(0, 7) == 0)
                    ? mco_pkg::RADIUS_WIDTH'($urandom_range(0, 16383))
                    : mco_pkg::RADIUS_WIDTH'($urandom_range(0, 12));
                send_start(mco_pkg::COORD_WIDTH'($urandom), mco_pkg::COORD_WIDTH'($urandom),
                           r, $urandom);
                if (r > 16)
                    nsteps = $urandom_range(1, 6);
                else if ($urandom_range(0, 1) == 1)
                    nsteps = r + 1;
                else
                    nsteps = $urandom_range(0, r + 1);
                repeat (nsteps) send_step();
            end
        end
        i_valid <= 1'b0;

        // Drain: wait for every predicted point, then give the block time to
        // show any extra word it should not send.
        @(posedge i_clk);
        while (pending_pixels != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("** midpoint_circle_outline: PASSED **");
        else
            $display("** midpoint_circle_outline: FAILED **");
        $finish;
    end

    // Hang guard: a correct run needs at most about a tenth of this.
    initial begin
        #3_000_000;
        $display("timeout with %0d points still expected", pending_pixels);
        $display("** midpoint_circle_outline: FAILED **");
        $finish;
    end

endmodule
